FILE: sv/rjd_pkg.sv
`timescale 1ns / 1ps

package rjd_pkg;

	// Command kinds carried in s_tuser
	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_INSERT = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	localparam int unsigned KIND_W  = 2;
	localparam int unsigned IDF_W   = 8;
	localparam int unsigned PARAM_W = 16;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned S_DATA_W = 32;
	localparam int unsigned M_DATA_W = 24;
	localparam int unsigned M_USER_W = 3;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted transaction
		logic commit;  // apply the command and load the output register
	} dp_cmd_t;

endpackage

FILE: sv/rjd_ram.sv
`timescale 1ns / 1ps

module rjd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/rjd_ctrl.sv
`timescale 1ns / 1ps

module rjd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output rjd_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && s_tvalid;
		cmd.commit = (state_q == ST_EXEC) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// hold until the output register can take the result
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					m_tvalid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: sv/rjd_dp.sv
`timescale 1ns / 1ps

module rjd_dp #(
	parameter int unsigned RING_DEPTH = 32,
	parameter int unsigned ID_BITS    = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rjd_pkg::dp_cmd_t                     cmd,
	input  logic [rjd_pkg::S_DATA_W-1:0]         s_tdata,
	input  logic [rjd_pkg::KIND_W-1:0]           s_tuser,
	output logic [rjd_pkg::M_DATA_W-1:0]         m_tdata,
	output logic [rjd_pkg::M_USER_W-1:0]         m_tuser
);

	localparam int unsigned IDX_W   = $clog2(RING_DEPTH);
	localparam int unsigned IDW     = (ID_BITS > rjd_pkg::IDF_W) ? ID_BITS : rjd_pkg::IDF_W;
	localparam int unsigned ENTRY_W = ID_BITS + rjd_pkg::PARAM_W + rjd_pkg::COUNT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	// captured transaction
	rjd_pkg::kind_t                kind_q;
	logic [ID_BITS-1:0]            id_q;
	logic [rjd_pkg::PARAM_W-1:0]   param_q;
	logic [rjd_pkg::COUNT_W-1:0]   count_q;

	logic [IDX_W-1:0]              head_q, tail_q;
	logic [ID_BITS-1:0]            act_id_q;
	logic [rjd_pkg::PARAM_W-1:0]   act_param_q;
	logic [rjd_pkg::COUNT_W-1:0]   act_count_q;

	logic [IDW-1:0]                in_id_ext;
	logic [IDW-1:0]                act_id_ext;

	logic [IDX_W-1:0]              head_next, head_prev, tail_next;
	logic                          ring_empty;
	logic                          add_ok, ins_ok;

	logic [ENTRY_W-1:0]            rd_entry;
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;

	logic [IDX_W-1:0]              head_d, tail_d;
	logic [ID_BITS-1:0]            act_id_d;
	logic [rjd_pkg::PARAM_W-1:0]   act_param_d;
	logic [rjd_pkg::COUNT_W-1:0]   act_count_d;
	logic                          disp_d, refused_d;

	assign in_id_ext  = IDW'(s_tdata[7:0]);
	assign act_id_ext = IDW'(act_id_q);

	assign head_next  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_prev  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_next  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign ring_empty = (head_q == tail_q);
	assign add_ok     = (tail_next != head_q);
	assign ins_ok     = (head_prev != tail_q);

	// The head entry is read continuously; the read data is settled in the
	// cycle after accept since pointers only move on commit.
	assign ram_we    = cmd.commit &&
	                   (((kind_q == rjd_pkg::KIND_ADD) && add_ok) ||
	                    ((kind_q == rjd_pkg::KIND_INSERT) && ins_ok));
	assign ram_waddr = (kind_q == rjd_pkg::KIND_ADD) ? tail_q : head_prev;

	rjd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({count_q, param_q, id_q}),
		.raddr (head_q),
		.rdata (rd_entry)
	);

	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		act_id_d    = act_id_q;
		act_param_d = act_param_q;
		act_count_d = act_count_q;
		disp_d      = 1'b0;
		refused_d   = 1'b0;
		unique case (kind_q)
			rjd_pkg::KIND_TICK: begin
				if (act_id_q != '0) begin
					if (act_count_q != '0) begin
						act_count_d = act_count_q - 1'b1;
						disp_d      = 1'b1;
					end else begin
						act_id_d    = '0;
						act_param_d = '0;
						act_count_d = '0;
					end
				end else if (!ring_empty) begin
					// promote the head entry into the active slot
					act_id_d    = rd_entry[ID_BITS-1:0];
					act_param_d = rd_entry[ID_BITS +: rjd_pkg::PARAM_W];
					act_count_d = rd_entry[ID_BITS + rjd_pkg::PARAM_W +: rjd_pkg::COUNT_W];
					head_d      = head_next;
				end
			end
			rjd_pkg::KIND_ADD: begin
				if (add_ok) begin
					tail_d = tail_next;
				end else begin
					refused_d = 1'b1;
				end
			end
			rjd_pkg::KIND_INSERT: begin
				if (ins_ok) begin
					head_d = head_prev;
				end else begin
					refused_d = 1'b1;
				end
			end
			rjd_pkg::KIND_CLEAR: begin
				if ((act_id_q == id_q) || (id_q == '0)) begin
					act_id_d    = '0;
					act_param_d = '0;
					act_count_d = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= rjd_pkg::kind_t'(s_tuser);
			id_q    <= in_id_ext[ID_BITS-1:0];
			param_q <= s_tdata[23:8];
			count_q <= s_tdata[31:24];
		end
		if (cmd.commit) begin
			m_tdata <= disp_d ? {act_param_q, act_id_ext[7:0]} : '0;
			m_tuser <= {(act_id_d != '0), refused_d, disp_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			act_id_q    <= '0;
			act_param_q <= '0;
			act_count_q <= '0;
		end else if (cmd.commit) begin
			head_q      <= head_d;
			tail_q      <= tail_d;
			act_id_q    <= act_id_d;
			act_param_q <= act_param_d;
			act_count_q <= act_count_d;
		end
	end

endmodule

FILE: sv/retry_job_deque.sv
`timescale 1ns / 1ps
// The result is registered when the execute state after acceptance commits; commit
// waits while the previous result still sits in the output register. A new input
// transaction is taken only in the idle state after that commit; the execute state
// covers the registered read of the ring RAM at the head pointer.
// Reset: head/tail pointers and the active slot clear at once; the ring RAM is
// not swept, since every entry between head and tail is written before it is read.

module retry_job_deque #(
	parameter int unsigned RING_DEPTH = 32,
	parameter int unsigned ID_BITS    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // job_id[7:0], job_param[23:8], repeat_count[31:24]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // dispatch_id[7:0], dispatch_param[23:8]
	output logic [2:0]  m_tuser   // dispatch[0], refused[1], active_busy[2]
);

	rjd_pkg::dp_cmd_t cmd;

	rjd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rjd_dp #(
		.RING_DEPTH (RING_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

FILE: sv/rjd_chk.sv
`timescale 1ns / 1ps

module rjd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one transaction at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous transaction in flight");

	a_idle_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
		else $error("payload nonzero without dispatch");

	a_refuse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("refused and dispatch together");

	a_disp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2])
		else $error("dispatch left active slot idle");

endmodule

bind retry_job_deque rjd_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
